>>> design/tdsp_pkg.sv
package tdsp_pkg;

    // Sizes of the queue group and of the payload fields
    localparam int QUEUE_CNT      = 16;
    localparam int Q_IDX_W        = 4;
    localparam int Q_NUM_W        = 5;
    localparam int CNT_W          = 11;
    localparam int TAG_W          = 16;
    localparam int CFG_DATA_W     = 11;
    localparam logic [CNT_W-1:0] QUEUE_CAPACITY = CNT_W'(1024);

    // Register reset values
    localparam logic [Q_NUM_W-1:0] ACTIVE_RST = Q_NUM_W'(1);
    localparam logic [CNT_W-1:0]   THRESH_RST = CNT_W'(5);

    typedef enum logic [0:0] {
        OPC_DISPATCH = 1'b0,
        OPC_REQUEST  = 1'b1
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_ACTIVE = 1'b0,
        CFG_THRESH = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        STAT_PLACED = 3'd0,
        STAT_FULL   = 3'd1,
        STAT_OWN    = 3'd2,
        STAT_STOLEN = 3'd3,
        STAT_NONE   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ALU_CMP,
        ALU_INC,
        ALU_DEC
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             ge;
        logic             gt;
        logic [CNT_W-1:0] res;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_D_WRAP,
        S_D_TEST,
        S_D_CHECK,
        S_D_INC,
        S_R_OWN,
        S_R_SCAN,
        S_R_END,
        S_R_DEC
    } t_state;

endpackage

>>> design/tdsp_alu.sv
module tdsp_alu (
    input  tdsp_pkg::t_alu_req i_req,
    output tdsp_pkg::t_alu_rsp o_rsp
);
    import tdsp_pkg::*;

    // Compare the count against the operand and step it up or down
    always_comb begin
        o_rsp.ge = (i_req.a >= i_req.b);
        o_rsp.gt = (i_req.a > i_req.b);
        case (i_req.op)
            ALU_INC: o_rsp.res = i_req.a + CNT_W'(1);
            ALU_DEC: o_rsp.res = i_req.a - CNT_W'(1);
            default: o_rsp.res = i_req.a;
        endcase
    end

endmodule

>>> design/tdsp_cnt_file.sv
module tdsp_cnt_file (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tdsp_pkg::Q_IDX_W-1:0]  i_rd_idx,
    output logic [tdsp_pkg::CNT_W-1:0]    o_rd_data,
    input  logic                          i_we,
    input  logic [tdsp_pkg::Q_IDX_W-1:0]  i_wr_idx,
    input  logic [tdsp_pkg::CNT_W-1:0]    i_wr_data
);
    import tdsp_pkg::*;

    logic [CNT_W-1:0] r_cnt [QUEUE_CNT];

    // Clear all occupancy counts at reset, update one per cycle when the write enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUEUE_CNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_we) begin
            r_cnt[i_wr_idx] <= i_wr_data;
        end
    end

    assign o_rd_data = r_cnt[i_rd_idx];

endmodule

>>> design/task_dispatch_and_steal_policy.sv
// Task dispatch and work-steal policy for up to 16 worker queues. The block keeps an
// 11-bit occupancy count per queue and a round-robin pointer; each request on the input
// channel yields exactly one result. One count is read and one compare or increment or
// decrement is done per cycle by a single shared unit under a small sequencer. A dispatch
// steps through the wrap, test and check states and then, unless the chosen queue is
// full, an increment; a request served from the worker's own queue takes the own-queue
// check and a decrement; a steal takes the own-queue check, a scan of one count per cycle
// over the N active queues, an end step and, unless nothing can be taken, a decrement.
// Input ready is held low while a request is in progress; a finished result waits in the
// output register while the next request is accepted. Configuration writes are taken at
// any time (ready is always high) and must only be issued while idle.
module task_dispatch_and_steal_policy (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_opcode,
    input  logic [tdsp_pkg::Q_IDX_W-1:0]     i_worker_index,
    input  logic [tdsp_pkg::TAG_W-1:0]       i_task_tag,
    // Result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [2:0]                       o_status,
    output logic [tdsp_pkg::Q_IDX_W-1:0]     o_queue_index,
    output logic [tdsp_pkg::TAG_W-1:0]       o_tag_out,
    output logic [tdsp_pkg::CNT_W-1:0]       o_queue_level,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [0:0]                       i_cfg_index,
    input  logic [tdsp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tdsp_pkg::*;

    t_state             r_state, n_state;
    t_opcode            r_op;
    logic [Q_IDX_W-1:0] r_w;
    logic [TAG_W-1:0]   r_tag;
    logic [Q_IDX_W-1:0] r_ptr;
    logic [Q_IDX_W-1:0] r_q;
    logic [Q_IDX_W-1:0] r_i;
    logic [Q_IDX_W-1:0] r_best;
    logic [CNT_W-1:0]   r_best_cnt;
    logic               r_steal;
    logic [Q_NUM_W-1:0] r_active;
    logic [CNT_W-1:0]   r_thresh;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [Q_IDX_W-1:0] r_out_qidx;
    logic [TAG_W-1:0]   r_out_tag;
    logic [CNT_W-1:0]   r_out_level;

    logic               in_acc;
    logic               out_free;
    logic [Q_NUM_W-1:0] grp_n;
    logic [Q_IDX_W-1:0] ptr_next;
    logic               scan_last;
    logic               w_in_grp;

    logic [Q_IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0]   rd_data;
    logic               cnt_we;
    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    logic               emit_want;
    logic               emit;
    t_status            emit_status;
    logic [Q_IDX_W-1:0] emit_qidx;
    logic [TAG_W-1:0]   emit_tag;
    logic [CNT_W-1:0]   emit_level;

    tdsp_cnt_file u_cnt_file (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data),
        .i_we      (cnt_we),
        .i_wr_idx  (r_q),
        .i_wr_data (alu_rsp.res)
    );

    tdsp_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Handshakes
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    // Clamp the group size to 1..QUEUE_CNT
    always_comb begin
        if (r_active == '0) begin
            grp_n = Q_NUM_W'(1);
        end else if (r_active > Q_NUM_W'(QUEUE_CNT)) begin
            grp_n = Q_NUM_W'(QUEUE_CNT);
        end else begin
            grp_n = r_active;
        end
    end

    assign ptr_next  = ((Q_NUM_W'(r_ptr) + Q_NUM_W'(1)) == grp_n) ? '0 : r_ptr + Q_IDX_W'(1);
    assign scan_last = (Q_NUM_W'(r_i) == grp_n - Q_NUM_W'(1));
    assign w_in_grp  = (Q_NUM_W'(r_w) < grp_n);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (t_opcode'(i_opcode) == OPC_DISPATCH) ? S_D_WRAP : S_R_OWN;
                end
            end
            S_D_WRAP:  n_state = S_D_TEST;
            S_D_TEST:  n_state = S_D_CHECK;
            S_D_CHECK: begin
                if (!alu_rsp.ge) begin
                    n_state = S_D_INC;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_D_INC: begin
                if (out_free) n_state = S_IDLE;
            end
            S_R_OWN: n_state = (w_in_grp && alu_rsp.gt) ? S_R_DEC : S_R_SCAN;
            S_R_SCAN: begin
                if (scan_last) n_state = S_R_END;
            end
            S_R_END: begin
                if (r_best_cnt != '0) begin
                    n_state = S_R_DEC;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_R_DEC: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs: count select, shared unit operands, result fields
    always_comb begin
        rd_idx      = r_q;
        alu_req.op  = ALU_CMP;
        alu_req.b   = '0;
        emit_want   = 1'b0;
        emit_status = STAT_NONE;
        emit_qidx   = r_q;
        emit_tag    = '0;
        emit_level  = '0;
        cnt_we      = 1'b0;
        unique case (r_state)
            S_D_TEST: begin
                rd_idx    = r_ptr;
                alu_req.b = r_thresh;
            end
            S_D_CHECK: begin
                alu_req.b   = QUEUE_CAPACITY;
                emit_want   = alu_rsp.ge;
                emit_status = STAT_FULL;
                emit_tag    = r_tag;
                emit_level  = rd_data;
            end
            S_D_INC: begin
                alu_req.op  = ALU_INC;
                emit_want   = 1'b1;
                emit_status = STAT_PLACED;
                emit_tag    = r_tag;
                emit_level  = alu_rsp.res;
                cnt_we      = out_free;
            end
            S_R_OWN: begin
                rd_idx = r_w;
            end
            S_R_SCAN: begin
                rd_idx    = r_i;
                alu_req.b = r_best_cnt;
            end
            S_R_END: begin
                emit_want   = (r_best_cnt == '0);
                emit_status = STAT_NONE;
                emit_qidx   = '0;
            end
            S_R_DEC: begin
                alu_req.op  = ALU_DEC;
                emit_want   = 1'b1;
                emit_status = r_steal ? STAT_STOLEN : STAT_OWN;
                emit_level  = alu_rsp.res;
                cnt_we      = out_free;
            end
            default: begin
                rd_idx = r_q;
            end
        endcase
        alu_req.a = rd_data;
    end

    assign emit = emit_want && out_free;

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the request and advance the pointer, own-queue check and scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op  <= t_opcode'(i_opcode);
                        r_w   <= i_worker_index;
                        r_tag <= i_task_tag;
                    end
                end
                S_D_WRAP: begin
                    if (Q_NUM_W'(r_ptr) >= grp_n) r_ptr <= '0;
                end
                S_D_TEST: begin
                    if (alu_rsp.ge) begin
                        r_ptr <= ptr_next;
                        r_q   <= ptr_next;
                    end else begin
                        r_q <= r_ptr;
                    end
                end
                S_R_OWN: begin
                    r_q        <= r_w;
                    r_steal    <= 1'b0;
                    r_i        <= '0;
                    r_best     <= '0;
                    r_best_cnt <= '0;
                end
                S_R_SCAN: begin
                    if (alu_rsp.gt) begin
                        r_best     <= r_i;
                        r_best_cnt <= rd_data;
                    end
                    r_i <= r_i + Q_IDX_W'(1);
                end
                S_R_END: begin
                    r_q     <= r_best;
                    r_steal <= 1'b1;
                end
                default: begin
                    r_ptr <= r_ptr;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RST;
            r_thresh <= THRESH_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ACTIVE: r_active <= i_cfg_data[Q_NUM_W-1:0];
                CFG_THRESH: r_thresh <= i_cfg_data[CNT_W-1:0];
                default:    r_active <= r_active;
            endcase
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_status <= emit_status;
            r_out_qidx   <= emit_qidx;
            r_out_tag    <= emit_tag;
            r_out_level  <= emit_level;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_queue_index = r_out_qidx;
    assign o_tag_out     = r_out_tag;
    assign o_queue_level = r_out_level;

    // A count never goes past the queue capacity
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> (alu_rsp.res <= QUEUE_CAPACITY))
        else $error("queue count written above capacity");

    // No result is produced in the cycle right after a request is taken
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !emit)
        else $error("result produced without sequencing");

    // Work-request results carry a zero tag
    a_req_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (r_op == OPC_REQUEST)) |-> (emit_tag == '0))
        else $error("nonzero tag on work-request result");

    // A steal result never names a queue outside the active group
    a_steal_grp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (emit_status == STAT_STOLEN)) |-> (Q_NUM_W'(emit_qidx) < grp_n))
        else $error("steal from inactive queue");

endmodule
